// ===== hdl/tcw_pkg.sv =====
// shared constants and types for the text console writer
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // character codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;

  // attribute after reset
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam int CELL_W = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUT_CURSOR = 2'd0,
    OP_PUT_POS    = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

endpackage

// ===== hdl/text_console_writer.sv =====
// text console writer: character-cell screen store with a write cursor
//
//  channel  | ports                      | beat contents
//  ---------+----------------------------+------------------------------------------
//  input    | in_tvalid/in_tready/in_tdata   | op, ch, row, col
//  result   | out_tvalid/out_tready/out_tdata| cursor row, cursor col, offset, cell word
//  config   | cfg_wen/cfg_wdata          | text attribute byte
//
// sweeps: a scroll and a clear are paced by the single write port of the screen ram,
//   one cell per cycle
// reset: after rst_n the block sweeps all ROWS*COLUMNS cells to blank with attribute
//   0x0F, one cell a cycle; in_tready stays low meanwhile
// stalls: a finished result waits in the output register; the next beat is taken
//   while it waits, and its own result holds until the output register is free
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,    // text_attribute
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // op[1:0], ch[9:2], row[14:10], col[21:15], zero
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata     // cursor_row_out[4:0], cursor_col_out[11:5],
                                    // cursor_offset[22:12], cell_word[38:23], zero
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
  localparam int CELL_W   = tcw_pkg::CELL_W;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(SCROLL_N);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // input field split
  tcw_pkg::op_t in_op;
  logic [7:0]   in_ch;
  logic [4:0]   in_row;
  logic [6:0]   in_col;

  assign in_op  = tcw_pkg::op_t'(in_tdata[1:0]);
  assign in_ch  = in_tdata[9:2];
  assign in_row = in_tdata[14:10];
  assign in_col = in_tdata[21:15];

  // registers
  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;          // sweep pointer
  logic              pend_r, pend_nxt;        // scroll copy waiting for read data
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     base_r, base_nxt;        // row_r * COLUMNS, kept incrementally
  logic [7:0]        attr_r, attr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0] word_r, word_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [38:0]       out_data_r, out_data_nxt;

  // ram port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic          in_fire;
  logic          in_range;
  logic [31:0]   pos_full;
  logic [AW-1:0] pos_addr;
  logic [31:0]   row_ext, col_ext, off_ext;

  assign in_fire  = in_tvalid && in_tready;
  assign in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));
  // row times a constant: shift-and-add after synthesis
  assign pos_full = 32'(in_row) * 32'(COLUMNS) + 32'(in_col);
  assign pos_addr = pos_full[AW-1:0];

  assign row_ext = 32'(row_r);
  assign col_ext = 32'(col_r);
  assign off_ext = 32'(base_r) + 32'(col_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    attr_nxt      = cfg_wen ? cfg_wdata : attr_r;
    rd_ok_nxt     = rd_ok_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_INIT: begin
        // power-up sweep: blank with the reset attribute
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CODE};
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          word_nxt  = '0;
          state_nxt = ST_DONE;
          unique case (in_op) inside
            tcw_pkg::OP_PUT_CURSOR, tcw_pkg::OP_PUT_POS: begin
              if (in_ch == tcw_pkg::NEWLINE_CODE) begin
                // newline from either put op
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  cnt_nxt   = '0;
                  state_nxt = ST_SCROLL;
                end else begin
                  row_nxt  = row_r + 1'b1;
                  base_nxt = base_r + ROW_STEP;
                end
              end else if (in_op == tcw_pkg::OP_PUT_CURSOR) begin
                wr_en   = 1'b1;
                wr_addr = base_r + AW'(col_r);
                wr_data = {attr_r, in_ch};
                if (col_r == LAST_COL) begin
                  col_nxt = '0;
                  if (row_r == LAST_ROW) begin
                    cnt_nxt   = '0;
                    state_nxt = ST_SCROLL;
                  end else begin
                    row_nxt  = row_r + 1'b1;
                    base_nxt = base_r + ROW_STEP;
                  end
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end else begin
                wr_en   = in_range;
                wr_addr = pos_addr;
                wr_data = {attr_r, in_ch};
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              base_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              rd_en     = in_range;
              rd_addr   = pos_addr;
              rd_ok_nxt = in_range;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        word_nxt  = rd_ok_r ? rd_data : '0;
        state_nxt = ST_DONE;
      end

      ST_SCROLL: begin
        // copy one cell up a row per cycle: read k+COLUMNS, write k next cycle
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data;
        end
        if (cnt_r != SCROLL_END) begin
          rd_en         = 1'b1;
          rd_addr       = cnt_r + ROW_STEP;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        // last row becomes zero words
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = '0;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = {attr_r, tcw_pkg::BLANK_CODE};
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {word_r, off_ext[10:0], col_ext[6:0], row_ext[4:0]};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      attr_r      <= attr_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    word_r      <= word_nxt;
    out_data_r  <= out_data_nxt;
  end

  // ram never sees a read and a write of the same cell in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("screen ram read and write collide");

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLUMNS)))
    else $error("cursor off screen");

  // incremental row base tracks the cursor row
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) == 32'(row_r) * 32'(COLUMNS))
    else $error("row base out of step with cursor row");

  // one beat in flight: an accepted beat closes the input until its result is in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input reopened while a beat is in work");

endmodule

// ===== hdl/tcw_ram.sv =====
// generic simple dual-port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
